// File: rtl/falu_pkg.sv
// falu_pkg: shared types and constants for the fixed-point ALU.
// Holds opcode codes, the port structs and the front-to-back item struct.
// No dependencies.
`default_nettype none
package falu_pkg;

  localparam logic [3:0] OP_ADD = 4'd0;
  localparam logic [3:0] OP_SUB = 4'd1;
  localparam logic [3:0] OP_MUL = 4'd2;
  localparam logic [3:0] OP_DIV = 4'd3;
  localparam logic [3:0] OP_GE  = 4'd4;
  localparam logic [3:0] OP_LE  = 4'd5;
  localparam logic [3:0] OP_EQ  = 4'd6;
  localparam logic [3:0] OP_NE  = 4'd7;
  localparam logic [3:0] OP_MIN = 4'd8;
  localparam logic [3:0] OP_MAX = 4'd9;

  localparam int QDEPTH = 4;
  localparam int QAW    = 2;

  typedef struct packed {
    logic [3:0]         opcode;
    logic signed [31:0] operand_a;
    logic signed [31:0] operand_b;
  } in_t;

  typedef struct packed {
    logic signed [31:0] value_out;
    logic               compare_true;
    logic               divide_by_zero;
  } out_t;

  typedef struct packed {
    logic [3:0]         opcode;
    logic               is_div;
    logic               is_mul;
    logic               div_zero;
    logic signed [31:0] a;
    logic signed [31:0] b;
  } item_t;

endpackage
`default_nettype wire

// File: rtl/falu_front.sv
// falu_front: input register that accepts words and classifies the opcode.
// Depends on falu_pkg.
`default_nettype none
module falu_front (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            in_valid,
  output logic                 in_stall,
  input  wire falu_pkg::in_t   in_data,
  input  wire logic            q_full,
  output logic                 push,
  output falu_pkg::item_t      item
);
  import falu_pkg::*;

  logic  fr_v_r, fr_v_nxt;
  item_t fr_r;
  logic  fire;

  assign in_stall = fr_v_r && q_full;
  assign fire     = in_valid && !in_stall;
  assign push     = fr_v_r && !q_full;
  assign item     = fr_r;

  always_comb begin
    fr_v_nxt = fr_v_r;
    if (fire) begin
      fr_v_nxt = 1'b1;
    end else if (push) begin
      fr_v_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fr_v_r <= 1'b0;
    end else begin
      fr_v_r <= fr_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      fr_r.opcode   <= in_data.opcode;
      fr_r.is_div   <= (in_data.opcode == OP_DIV);
      fr_r.is_mul   <= (in_data.opcode == OP_MUL);
      fr_r.div_zero <= (in_data.opcode == OP_DIV) && (in_data.operand_b == 32'sd0);
      fr_r.a        <= in_data.operand_a;
      fr_r.b        <= in_data.operand_b;
    end
  end

endmodule
`default_nettype wire

// File: rtl/falu_queue.sv
// falu_queue: short FIFO between the front and the back of the ALU.
// Depends on falu_pkg.
`default_nettype none
module falu_queue (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            push,
  input  wire falu_pkg::item_t wr_item,
  input  wire logic            pop,
  output logic                 full,
  output logic                 not_empty,
  output falu_pkg::item_t      rd_item
);
  import falu_pkg::*;

  item_t            mem [QDEPTH];
  logic [QAW-1:0]   wp_r, rp_r;
  logic [QAW:0]     cnt_r, cnt_nxt;
  logic             do_pop;

  assign full      = (cnt_r == (QAW+1)'(QDEPTH));
  assign not_empty = (cnt_r != '0);
  assign do_pop    = pop && not_empty;
  assign rd_item   = mem[rp_r];

  always_comb begin
    cnt_nxt = cnt_r;
    if (push && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (!push && do_pop) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
      if (push) begin
        wp_r <= wp_r + 1'b1;
      end
      if (do_pop) begin
        rp_r <= rp_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wp_r] <= wr_item;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    full |-> !push)
    else $error("queue written while full");

  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= (QAW+1)'(QDEPTH))
    else $error("queue count out of range");

  a_pop_count: assert property (@(posedge clk) disable iff (!rst_n)
    (do_pop && !push) |=> (cnt_r == $past(cnt_r) - 1'b1))
    else $error("queue count did not drop on pop");

endmodule
`default_nettype wire

// File: rtl/falu_back.sv
// falu_back: execution pipeline with pipelined restoring divider,
// multiplier stage and output register. Depends on falu_pkg.
`default_nettype none
module falu_back #(
  parameter int FRAC_BITS = 8
) (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            q_not_empty,
  input  wire falu_pkg::item_t q_item,
  output logic                 pop,
  output logic                 out_valid,
  input  wire logic            out_stall,
  output falu_pkg::out_t       out_data
);
  import falu_pkg::*;

  localparam int NW = 32 + FRAC_BITS;
  localparam int S  = NW + 1;

  logic               adv;
  logic               v_r   [S];
  logic [31:0]        res_r [S];
  logic               cmp_r [S];
  logic               dz_r  [S];
  logic               div_r [S];
  logic               neg_r [S];
  logic [31:0]        rem_r [S];
  logic [NW-1:0]      n_r   [S];
  logic [31:0]        d_r   [S];
  logic signed [63:0] prod_r;
  logic               mul_r;
  logic signed [63:0] prod_sh;

  logic               out_valid_r;
  out_t               out_r;

  logic [31:0]        res0;
  logic               cmp0;
  logic [31:0]        abs_a, abs_b;
  logic [31:0]        q_lo, q_signed;

  assign adv       = !out_valid_r || !out_stall;
  assign pop       = adv && q_not_empty;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;
  assign prod_sh   = prod_r >>> FRAC_BITS;

  always_comb begin
    res0 = '0;
    cmp0 = 1'b0;
    case (q_item.opcode)
      OP_ADD: res0 = q_item.a + q_item.b;
      OP_SUB: res0 = q_item.a - q_item.b;
      OP_GE:  cmp0 = (q_item.a >= q_item.b);
      OP_LE:  cmp0 = (q_item.a <= q_item.b);
      OP_EQ:  cmp0 = (q_item.a == q_item.b);
      OP_NE:  cmp0 = (q_item.a != q_item.b);
      OP_MIN: res0 = (q_item.a <= q_item.b) ? q_item.a : q_item.b;
      OP_MAX: res0 = (q_item.a >= q_item.b) ? q_item.a : q_item.b;
      default: res0 = '0;
    endcase
    abs_a = q_item.a[31] ? 32'(-q_item.a) : q_item.a;
    abs_b = q_item.b[31] ? 32'(-q_item.b) : q_item.b;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r[0] <= 1'b0;
    end else if (adv) begin
      v_r[0] <= q_not_empty;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      res_r[0] <= res0;
      cmp_r[0] <= cmp0;
      dz_r[0]  <= q_item.div_zero;
      div_r[0] <= q_item.is_div;
      neg_r[0] <= q_item.a[31] ^ q_item.b[31];
      rem_r[0] <= '0;
      n_r[0]   <= {abs_a, FRAC_BITS'(0)};
      d_r[0]   <= abs_b;
      prod_r   <= q_item.a * q_item.b;
      mul_r    <= q_item.is_mul;
    end
  end

  for (genvar k = 1; k < S; k++) begin : g_stage
    logic [32:0] r2, diff;
    logic        ge;

    always_comb begin
      r2   = {rem_r[k-1], n_r[k-1][NW-1]};
      diff = r2 - {1'b0, d_r[k-1]};
      ge   = (r2 >= {1'b0, d_r[k-1]});
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[k] <= 1'b0;
      end else if (adv) begin
        v_r[k] <= v_r[k-1];
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        res_r[k] <= ((k == 1) && mul_r) ? prod_sh[31:0] : res_r[k-1];
        cmp_r[k] <= cmp_r[k-1];
        dz_r[k]  <= dz_r[k-1];
        div_r[k] <= div_r[k-1];
        neg_r[k] <= neg_r[k-1];
        rem_r[k] <= ge ? diff[31:0] : r2[31:0];
        n_r[k]   <= {n_r[k-1][NW-2:0], ge};
        d_r[k]   <= d_r[k-1];
      end
    end
  end

  assign q_lo     = n_r[S-1][31:0];
  assign q_signed = neg_r[S-1] ? 32'(-q_lo) : q_lo;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= v_r[S-1];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_r.value_out      <= div_r[S-1] ? (dz_r[S-1] ? '0 : q_signed) : res_r[S-1];
      out_r.compare_true   <= cmp_r[S-1];
      out_r.divide_by_zero <= dz_r[S-1];
    end
  end

  a_dz_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_r.divide_by_zero) |-> (out_r.value_out == '0 && !out_r.compare_true))
    else $error("divide by zero result not cleared");

  a_cmp_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_r.compare_true) |-> (out_r.value_out == '0))
    else $error("comparison result carries a value");

  a_shift: assert property (@(posedge clk) disable iff (!rst_n)
    adv |=> (v_r[1] == $past(v_r[0])))
    else $error("pipeline valid lost or duplicated");

endmodule
`default_nettype wire

// File: rtl/fixed_point_alu.sv
// fixed_point_alu: top level of the signed fixed-point ALU.
// Instantiates falu_front, falu_queue and falu_back; uses falu_pkg.
//
// Usage: the input channel (in_valid, in_stall, in_data) takes one word per
// cycle while in_stall is low: an opcode and two 32-bit raw operands with
// FRAC_BITS fraction bits. The result channel (out_valid, out_stall,
// out_data) returns one word per input word, in order: value, compare
// flag and divide-by-zero flag.
// Throughput: one word per cycle while out_stall is low.
// The divider retires one quotient bit per stage over 32 + FRAC_BITS
// stages; every opcode travels the same pipeline so order is kept.
// When the receiver stalls, the result register holds, the execution
// pipeline freezes, the four-entry queue fills and then in_stall rises.
// Reset (rst_n low, synchronous) empties the front register, the queue and
// all pipeline valid bits; no result is pending after reset.
`default_nettype none
module fixed_point_alu #(
  parameter int FRAC_BITS = 8
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_valid,
  output logic               in_stall,
  input  wire falu_pkg::in_t in_data,
  output logic               out_valid,
  input  wire logic          out_stall,
  output falu_pkg::out_t     out_data
);
  import falu_pkg::*;

  logic  q_full, q_not_empty, push, pop;
  item_t f_item, q_item;

  falu_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .q_full   (q_full),
    .push     (push),
    .item     (f_item)
  );

  falu_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .wr_item   (f_item),
    .pop       (pop),
    .full      (q_full),
    .not_empty (q_not_empty),
    .rd_item   (q_item)
  );

  falu_back #(.FRAC_BITS(FRAC_BITS)) u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .q_not_empty (q_not_empty),
    .q_item      (q_item),
    .pop         (pop),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_data    (out_data)
  );

endmodule
`default_nettype wire

// File: bench/tb_top.sv
// tb_top: self-checking bench for fixed_point_alu (FRAC_BITS = 8).
// Drives a directed table, then random words; checks each result against the table or predictor.
// Depends on falu_pkg and the fixed_point_alu RTL.
`default_nettype none
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import falu_pkg::*;

  localparam int FB = 8;
  localparam int LAT = FB + 36;
  localparam int N_RAND = 1130;
  localparam longint CYCLE_LIMIT = 400000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  in_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  out_t out_data;

  int src_idle_pct = 0;
  int snk_idle_pct = 0;
  int hold_cycles = 0;
  int errors = 0;
  longint cycles = 0;
  out_t alu_expect_q[$];

  always #6 clk = ~clk;

  fixed_point_alu #(.FRAC_BITS(FB)) u_dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
  );

  function automatic out_t alu_predict(in_t w);
    out_t r;
    logic signed [63:0] a, b, p, q;
    r = '0;
    a = 64'(w.operand_a);
    b = 64'(w.operand_b);
    case (w.opcode)
      OP_ADD: r.value_out = w.operand_a + w.operand_b;
      OP_SUB: r.value_out = w.operand_a - w.operand_b;
      OP_MUL: begin
        p = a * b;
        p = p >>> FB;
        r.value_out = p[31:0];
      end
      OP_DIV: begin
        if (b == 0) begin
          r.divide_by_zero = 1'b1;
        end else begin
          q = (a <<< FB) / b;
          r.value_out = q[31:0];
        end
      end
      OP_GE: r.compare_true = (a >= b);
      OP_LE: r.compare_true = (a <= b);
      OP_EQ: r.compare_true = (a == b);
      OP_NE: r.compare_true = (a != b);
      OP_MIN: r.value_out = (a <= b) ? w.operand_a : w.operand_b;
      OP_MAX: r.value_out = (a >= b) ? w.operand_a : w.operand_b;
      default: r = '0;
    endcase
    return r;
  endfunction

  typedef struct {
    in_t  w;
    logic known;
    out_t res;
  } vec_t;

  localparam logic signed [31:0] MX = 32'sh7fffffff;
  localparam logic signed [31:0] MN = 32'sh80000000;
  localparam logic [3:0] OP_UNUSED_LO = 4'd10;
  localparam logic [3:0] OP_UNUSED_HI = 4'd15;

  vec_t dir_tab[] = '{
    '{'{OP_ADD, MX, 32'sd1}, 1'b1, '{MN, 1'b0, 1'b0}},
    '{'{OP_SUB, MN, 32'sd1}, 1'b1, '{MX, 1'b0, 1'b0}},
    '{'{OP_ADD, 32'sd256, 32'sd512}, 1'b1, '{32'sd768, 1'b0, 1'b0}},
    '{'{OP_MUL, 32'sd512, 32'sd768}, 1'b1, '{32'sd1536, 1'b0, 1'b0}},
    '{'{OP_MUL, MX, MX}, 1'b0, '0},
    '{'{OP_MUL, MN, MN}, 1'b0, '0},
    '{'{OP_MUL, -32'sd1, 32'sd1}, 1'b1, '{-32'sd1, 1'b0, 1'b0}},
    '{'{OP_DIV, 32'sd768, 32'sd0}, 1'b1, '{32'sd0, 1'b0, 1'b1}},
    '{'{OP_DIV, 32'sd0, 32'sd0}, 1'b1, '{32'sd0, 1'b0, 1'b1}},
    '{'{OP_DIV, 32'sd768, 32'sd512}, 1'b1, '{32'sd384, 1'b0, 1'b0}},
    '{'{OP_DIV, MN, -32'sd1}, 1'b0, '0},
    '{'{OP_DIV, MX, 32'sd1}, 1'b0, '0},
    '{'{OP_DIV, -32'sd3, 32'sd512}, 1'b0, '0},
    '{'{OP_GE, 32'sd5, 32'sd5}, 1'b1, '{32'sd0, 1'b1, 1'b0}},
    '{'{OP_GE, MN, MX}, 1'b1, '{32'sd0, 1'b0, 1'b0}},
    '{'{OP_LE, MN, MX}, 1'b1, '{32'sd0, 1'b1, 1'b0}},
    '{'{OP_EQ, MX, MX}, 1'b1, '{32'sd0, 1'b1, 1'b0}},
    '{'{OP_NE, MX, MX}, 1'b1, '{32'sd0, 1'b0, 1'b0}},
    '{'{OP_MIN, MN, MX}, 1'b1, '{MN, 1'b0, 1'b0}},
    '{'{OP_MAX, MN, MX}, 1'b1, '{MX, 1'b0, 1'b0}},
    '{'{OP_MIN, 32'sd7, 32'sd7}, 1'b1, '{32'sd7, 1'b0, 1'b0}},
    '{'{OP_MAX, -32'sd7, -32'sd7}, 1'b1, '{-32'sd7, 1'b0, 1'b0}},
    '{'{OP_UNUSED_LO, MX, MN}, 1'b1, '0},
    '{'{OP_UNUSED_HI, -32'sd1, -32'sd1}, 1'b1, '0}
  };

  function automatic logic signed [31:0] rand_operand();
    case ($urandom_range(0, 7))
      0: return MX;
      1: return MN;
      2: return 32'sd0;
      3: return 32'($signed($urandom_range(0, 2047)) - 1024);
      default: return $signed($urandom);
    endcase
  endfunction

  task automatic send_word(in_t w, logic known, out_t res);
    while ($urandom_range(0, 99) < src_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= w;
    alu_expect_q.push_back(known ? res : alu_predict(w));
    do @(posedge clk); while (in_stall);
  endtask

  task automatic set_phase(int s, int r);
    src_idle_pct = s;
    snk_idle_pct = r;
  endtask

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else if (hold_cycles > 0) begin
      out_stall <= 1'b1;
      hold_cycles <= hold_cycles - 1;
    end else begin
      out_stall <= ($urandom_range(0, 99) < snk_idle_pct);
    end
  end

  always @(posedge clk) begin
    out_t exp_w;
    if (rst_n && out_valid && !out_stall) begin
      if (alu_expect_q.size() == 0) begin
        $display("%0t unexpected word: actual %h", $realtime, out_data);
        errors = errors + 1;
      end else begin
        exp_w = alu_expect_q.pop_front();
        if (out_data.value_out !== exp_w.value_out) begin
          $display("%0t value_out: expected %h actual %h", $realtime,
                   exp_w.value_out, out_data.value_out);
          errors = errors + 1;
        end
        if (out_data.compare_true !== exp_w.compare_true) begin
          $display("%0t compare_true: expected %b actual %b", $realtime,
                   exp_w.compare_true, out_data.compare_true);
          errors = errors + 1;
        end
        if (out_data.divide_by_zero !== exp_w.divide_by_zero) begin
          $display("%0t divide_by_zero: expected %b actual %b", $realtime,
                   exp_w.divide_by_zero, out_data.divide_by_zero);
          errors = errors + 1;
        end
      end
    end
  end

  initial begin
    in_t w;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    foreach (dir_tab[i]) send_word(dir_tab[i].w, dir_tab[i].known, dir_tab[i].res);
    for (int i = 0; i < N_RAND; i++) begin
      case (i)
        0:   set_phase(0, 0);
        150: hold_cycles = 200;
        300: set_phase(45, 0);
        550: set_phase(0, 45);
        800: set_phase(36, 36);
        1000: set_phase(0, 0);
        default: ;
      endcase
      w.opcode = ($urandom_range(0, 19) == 0) ? 4'($urandom_range(10, 15))
                                              : 4'($urandom_range(0, 9));
      w.operand_a = rand_operand();
      w.operand_b = rand_operand();
      if (w.opcode inside {OP_EQ, OP_NE, OP_MIN, OP_MAX} && $urandom_range(0, 3) == 0)
        w.operand_b = w.operand_a;
      send_word(w, 1'b0, '0);
    end
    in_valid <= 1'b0;
    set_phase(0, 0);
    while (alu_expect_q.size() != 0) @(posedge clk);
    repeat (LAT + 10) @(posedge clk);
    if (errors == 0 && alu_expect_q.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end
endmodule
`default_nettype wire
